### design/controlled_gate_state_sweep_unit_assert.svh
// ----------------------------------------------------------------------------
// controlled_gate_state_sweep_unit assertion macros
// Concurrent assertion wrappers used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef CONTROLLED_GATE_STATE_SWEEP_UNIT_ASSERT_SVH
`define CONTROLLED_GATE_STATE_SWEEP_UNIT_ASSERT_SVH

// check outside reset
`define CGSS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define CGSS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/cgss_pkg.sv
// ----------------------------------------------------------------------------
// cgss_pkg
// Types, constants and amplitude helpers of the gate state sweep unit.
// ----------------------------------------------------------------------------
package cgss_pkg;

  localparam int MAX_QUBITS    = 10;
  localparam int AMP_PART_BITS = 32;

  localparam int FIELD_W     = 32;
  localparam int FUNC_W      = 2;
  localparam int QUBIT_W     = 4;
  localparam int AMP_ADDR_W  = 10;
  localparam int CFG_W       = 4;
  localparam int ADDR_W      = MAX_QUBITS;
  localparam int PAIR_W      = MAX_QUBITS - 2;
  localparam int QCNT_W      = ($clog2(MAX_QUBITS + 1) > QUBIT_W) ?
                               $clog2(MAX_QUBITS + 1) : QUBIT_W;
  localparam int MIN_QUBITS  = 2;
  localparam int HI_W        = FIELD_W - AMP_PART_BITS + 1;

  localparam logic [CFG_W-1:0] QCNT_RESET = CFG_W'(10);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CNOT  = 2'd2,
    FUNC_CZ    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_RD_A,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B,
    ST_DONE
  } state_e;

  typedef logic [AMP_PART_BITS-1:0] part_t;

  typedef struct packed {
    part_t re;
    part_t im;
  } amp_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    amp_t              wdata;
  } mem_req_t;

  localparam part_t PART_MIN = {1'b1, {(AMP_PART_BITS-1){1'b0}}};
  localparam part_t PART_MAX = {1'b0, {(AMP_PART_BITS-1){1'b1}}};

  function automatic part_t sat_part(input logic [FIELD_W-1:0] v);
    logic [HI_W-1:0] hi;
    hi = v[FIELD_W-1:AMP_PART_BITS-1];
    if ((&hi) || !(|hi)) begin
      return v[AMP_PART_BITS-1:0];
    end
    return v[FIELD_W-1] ? PART_MIN : PART_MAX;
  endfunction

  function automatic part_t neg_part(input part_t p);
    if (p == PART_MIN) begin
      return PART_MAX;
    end
    return part_t'(-p);
  endfunction

  function automatic logic [FIELD_W-1:0] sext_part(input part_t p);
    logic signed [AMP_PART_BITS-1:0] s;
    s = p;
    return FIELD_W'(s);
  endfunction

endpackage

### design/cgss_amp_ram.sv
// ----------------------------------------------------------------------------
// cgss_amp_ram
// Single-port amplitude memory with registered read data.
// ----------------------------------------------------------------------------
module cgss_amp_ram
  import cgss_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output amp_t     rdata_o
);

  localparam int DEPTH = 1 << ADDR_W;

  amp_t mem_q [DEPTH];
  amp_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/cgss_seq.sv
// ----------------------------------------------------------------------------
// cgss_seq
// Item sequencer: checks indices, walks gate pairs and drives the memory port.
// ----------------------------------------------------------------------------
module cgss_seq
  import cgss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [QUBIT_W-1:0]    control_qubit_i,
  input  logic [QUBIT_W-1:0]    target_qubit_i,
  input  logic [AMP_ADDR_W-1:0] amp_address_i,
  input  logic [FIELD_W-1:0]    write_real_i,
  input  logic [FIELD_W-1:0]    write_imag_i,
  input  logic [CFG_W-1:0]      qubit_count_i,
  input  amp_t                  rdata_i,
  output mem_req_t              mem_req_o,
  output logic                  busy_o,
  output logic                  result_valid_o,
  output logic [FIELD_W-1:0]    read_real_o,
  output logic [FIELD_W-1:0]    read_imag_o,
  output logic                  status_o
);

  state_e              state_q, state_d;
  logic [PAIR_W-1:0]   pair_q, pair_d;
  logic [PAIR_W-1:0]   last_q;
  logic                status_q;
  logic                is_read_q;
  logic                is_cz_q;
  logic [ADDR_W-1:0]   addr_q;
  amp_t                wdata_q;
  amp_t                hold_q;
  logic [ADDR_W-1:0]   cm_q, tm_q, lm_q, hm_q;

  func_e               func;
  logic [QCNT_W-1:0]   qcnt, n_act, ctl, tgt, lo, hi;
  logic                addr_bad, gate_bad, err, accept;
  logic [ADDR_W-1:0]   pair_ext, ins_lo, base, idx_a, idx_b;
  amp_t                neg_word;

  assign func   = func_e'(func_i);
  assign accept = (state_q == ST_IDLE) && start_i;
  assign qcnt   = QCNT_W'(qubit_count_i);
  assign ctl    = QCNT_W'(control_qubit_i);
  assign tgt    = QCNT_W'(target_qubit_i);

  always_comb begin
    n_act = qcnt;
    if (qcnt < QCNT_W'(MIN_QUBITS)) begin
      n_act = QCNT_W'(MIN_QUBITS);
    end else if (qcnt > QCNT_W'(MAX_QUBITS)) begin
      n_act = QCNT_W'(MAX_QUBITS);
    end
  end

  assign addr_bad = (amp_address_i >> n_act) != '0;
  assign gate_bad = (ctl == tgt) || (ctl >= n_act) || (tgt >= n_act);
  assign err      = ((func == FUNC_WRITE) || (func == FUNC_READ)) ? addr_bad : gate_bad;
  assign lo       = (ctl < tgt) ? ctl : tgt;
  assign hi       = (ctl < tgt) ? tgt : ctl;

  assign pair_ext = ADDR_W'(pair_q);
  assign ins_lo   = ((pair_ext & ~lm_q) << 1) | (pair_ext & lm_q);
  assign base     = ((ins_lo & ~hm_q) << 1) | (ins_lo & hm_q);
  assign idx_a    = base | cm_q;
  assign idx_b    = base | cm_q | tm_q;

  assign neg_word.re = neg_part(rdata_i.re);
  assign neg_word.im = neg_part(rdata_i.im);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pair_q    <= '0;
      last_q    <= '0;
      status_q  <= 1'b0;
      is_read_q <= 1'b0;
      is_cz_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pair_q  <= pair_d;
      if (accept) begin
        last_q    <= ~({PAIR_W{1'b1}} << (n_act - QCNT_W'(MIN_QUBITS)));
        status_q  <= err;
        is_read_q <= !err && (func == FUNC_READ);
        is_cz_q   <= (func == FUNC_CZ);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q     <= ADDR_W'(amp_address_i);
      wdata_q.re <= sat_part(write_real_i);
      wdata_q.im <= sat_part(write_imag_i);
      cm_q       <= ADDR_W'(1) << ctl;
      tm_q       <= ADDR_W'(1) << tgt;
      lm_q       <= (ADDR_W'(1) << lo) - ADDR_W'(1);
      hm_q       <= (ADDR_W'(1) << hi) - ADDR_W'(1);
    end
    if (state_q == ST_RD_B) begin
      hold_q <= rdata_i;
    end
  end

  always_comb begin
    state_d         = state_q;
    pair_d          = pair_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.addr  = idx_a;
    mem_req_o.wdata = rdata_i;
    case (state_q)
      ST_IDLE: begin
        pair_d = '0;
        if (start_i) begin
          if (err) begin
            state_d = ST_DONE;
          end else begin
            case (func)
              FUNC_WRITE: state_d = ST_WRITE;
              FUNC_READ:  state_d = ST_READ;
              FUNC_CNOT:  state_d = ST_RD_A;
              FUNC_CZ:    state_d = ST_RD_B;
              default:    state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_WRITE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = addr_q;
        mem_req_o.wdata = wdata_q;
        state_d         = ST_DONE;
      end
      ST_READ: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = addr_q;
        state_d        = ST_DONE;
      end
      ST_RD_A: begin
        mem_req_o.re = 1'b1;
        state_d      = ST_RD_B;
      end
      ST_RD_B: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = idx_b;
        state_d        = is_cz_q ? ST_WR_B : ST_WR_A;
      end
      ST_WR_A: begin
        mem_req_o.we = 1'b1;
        state_d      = ST_WR_B;
      end
      ST_WR_B: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = idx_b;
        mem_req_o.wdata = is_cz_q ? neg_word : hold_q;
        if (pair_q == last_q) begin
          state_d = ST_DONE;
        end else begin
          pair_d  = pair_q + PAIR_W'(1);
          state_d = is_cz_q ? ST_RD_B : ST_RD_A;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_DONE);
  assign status_o       = result_valid_o && status_q;
  assign read_real_o    = (result_valid_o && is_read_q) ? sext_part(rdata_i.re) : '0;
  assign read_imag_o    = (result_valid_o && is_read_q) ? sext_part(rdata_i.im) : '0;

endmodule

### design/controlled_gate_state_sweep_unit.sv
// ----------------------------------------------------------------------------
// controlled_gate_state_sweep_unit
// State vector memory with amplitude write, read, CNOT and CZ sweeps.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its one result is
// shown for a single cycle with result_valid_o and cannot be held off, so the
// receiver must take it then. A write passes through the WRITE and DONE
// states, a read through READ and DONE, an error goes straight to DONE. Gates
// run over the single memory port: CNOT does two reads and two writes per
// pair, CZ one read and one write per pair, over 2^(n-2) pairs. busy drops in
// the cycle after the result. qubit_count is written through the cfg channel
// while the block is idle; amplitudes must be written before read.
// ----------------------------------------------------------------------------
module controlled_gate_state_sweep_unit
  import cgss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [QUBIT_W-1:0]    control_qubit_i,
  input  logic [QUBIT_W-1:0]    target_qubit_i,
  input  logic [AMP_ADDR_W-1:0] amp_address_i,
  input  logic [FIELD_W-1:0]    write_real_i,
  input  logic [FIELD_W-1:0]    write_imag_i,
  output logic                  result_valid_o,
  output logic [FIELD_W-1:0]    read_real_o,
  output logic [FIELD_W-1:0]    read_imag_o,
  output logic                  status_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  logic [CFG_W-1:0] qubit_count_q;
  mem_req_t         mem_req;
  amp_t             rdata;

  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qubit_count_q <= QCNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      qubit_count_q <= cfg_data_i;
    end
  end

  cgss_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .func_i          (func_i),
    .control_qubit_i (control_qubit_i),
    .target_qubit_i  (target_qubit_i),
    .amp_address_i   (amp_address_i),
    .write_real_i    (write_real_i),
    .write_imag_i    (write_imag_i),
    .qubit_count_i   (qubit_count_q),
    .rdata_i         (rdata),
    .mem_req_o       (mem_req),
    .busy_o          (busy),
    .result_valid_o  (result_valid_o),
    .read_real_o     (read_real_o),
    .read_imag_o     (read_imag_o),
    .status_o        (status_o)
  );

  cgss_amp_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

endmodule

### design/cgss_checker.sv
// ----------------------------------------------------------------------------
// cgss_checker
// Port-level checks of the gate state sweep unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "controlled_gate_state_sweep_unit_assert.svh"

module cgss_checker
  import cgss_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               result_valid_o,
  input logic [FIELD_W-1:0] read_real_o,
  input logic [FIELD_W-1:0] read_imag_o,
  input logic               status_o
);

  `CGSS_ASSERT(a_accept_busy, start && !busy |=> busy, "item accepted but block not busy")
  `CGSS_ASSERT(a_result_busy, result_valid_o |-> busy, "result shown while idle")
  `CGSS_ASSERT(a_result_pulse, result_valid_o |=> !result_valid_o && !busy, "result not a single pulse")
  `CGSS_ASSERT(a_err_zero, result_valid_o && status_o |-> read_real_o == 0 && read_imag_o == 0, "error result carries data")
  `CGSS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !busy && !result_valid_o, "busy during reset")

endmodule

bind controlled_gate_state_sweep_unit cgss_checker u_checker (.*);

### bench/controlled_gate_state_sweep_unit_tb.sv
// ----------------------------------------------------------------------------
// controlled_gate_state_sweep_unit_tb
// Drives amplitude writes, reads and CNOT/CZ sweeps through the command port
// and checks every result against a scoreboard that mirrors the state vector.
// The run steps qubit_count through several sizes, the clamped extremes
// included. Within each size it mixes well-formed gates, addressed reads and
// writes, and bad indices and addresses. In-range reads only target entries
// that hold written data.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module controlled_gate_state_sweep_unit_tb;
  import cgss_pkg::*;

  localparam int AMP_SLOTS       = 1 << MAX_QUBITS;
  localparam int PLAN_LEN        = 11;
  localparam int ITEMS_PER_PHASE = 52;
  localparam int TIMEOUT_NS      = 5_000_000;

  typedef struct {
    logic [FIELD_W-1:0] re;
    logic [FIELD_W-1:0] im;
    logic               status;
  } readback_t;

  class gate_sweep_scoreboard;
    part_t            amp_re  [AMP_SLOTS];
    part_t            amp_im  [AMP_SLOTS];
    bit               written [AMP_SLOTS];
    logic [CFG_W-1:0] qubit_count;
    readback_t        expected_results [$];
    int unsigned      mismatches;

    function new();
      qubit_count = QCNT_RESET;
      mismatches  = 0;
    endfunction

    function int unsigned active_qubits();
      if (qubit_count < MIN_QUBITS) begin
        return MIN_QUBITS;
      end
      if (qubit_count > MAX_QUBITS) begin
        return MAX_QUBITS;
      end
      return 32'(qubit_count);
    endfunction

    function part_t negate_sat(input part_t p);
      if (p == PART_MIN) begin
        return PART_MAX;
      end
      return -p;
    endfunction

    function void note_item(input func_e f, input logic [QUBIT_W-1:0] ctl,
                            input logic [QUBIT_W-1:0] tgt,
                            input logic [AMP_ADDR_W-1:0] addr,
                            input logic [FIELD_W-1:0] wr,
                            input logic [FIELD_W-1:0] wi);
      int unsigned n;
      int unsigned size;
      int unsigned partner;
      part_t       hold_re;
      part_t       hold_im;
      bit          hold_wr;
      readback_t   res;
      n          = active_qubits();
      size       = 1 << n;
      res.re     = '0;
      res.im     = '0;
      res.status = 1'b0;
      if (f == FUNC_WRITE || f == FUNC_READ) begin
        if (addr >= size) begin
          res.status = 1'b1;
        end else if (f == FUNC_WRITE) begin
          amp_re[addr]  = part_t'(wr);
          amp_im[addr]  = part_t'(wi);
          written[addr] = 1'b1;
        end else begin
          res.re = FIELD_W'(signed'(amp_re[addr]));
          res.im = FIELD_W'(signed'(amp_im[addr]));
        end
      end else if (ctl == tgt || ctl >= n || tgt >= n) begin
        res.status = 1'b1;
      end else begin
        for (int i = 0; i < size; i++) begin
          if (i[ctl]) begin
            if (f == FUNC_CNOT && !i[tgt]) begin
              partner          = i | (1 << tgt);
              hold_re          = amp_re[i];
              hold_im          = amp_im[i];
              hold_wr          = written[i];
              amp_re[i]        = amp_re[partner];
              amp_im[i]        = amp_im[partner];
              written[i]       = written[partner];
              amp_re[partner]  = hold_re;
              amp_im[partner]  = hold_im;
              written[partner] = hold_wr;
            end else if (f == FUNC_CZ && i[tgt]) begin
              amp_re[i] = negate_sat(amp_re[i]);
              amp_im[i] = negate_sat(amp_im[i]);
            end
          end
        end
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(input logic [FIELD_W-1:0] rr,
                               input logic [FIELD_W-1:0] ri, input logic st);
      readback_t exp_res;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing pending: re %h im %h status %b",
                 $time, rr, ri, st);
        mismatches++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (rr !== exp_res.re) begin
        $display("%0t: read_real expected %h, actual %h", $time, exp_res.re, rr);
        mismatches++;
      end
      if (ri !== exp_res.im) begin
        $display("%0t: read_imag expected %h, actual %h", $time, exp_res.im, ri);
        mismatches++;
      end
      if (st !== exp_res.status) begin
        $display("%0t: status expected %b, actual %b", $time, exp_res.status, st);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [FUNC_W-1:0]     func_i;
  logic [QUBIT_W-1:0]    control_qubit_i;
  logic [QUBIT_W-1:0]    target_qubit_i;
  logic [AMP_ADDR_W-1:0] amp_address_i;
  logic [FIELD_W-1:0]    write_real_i;
  logic [FIELD_W-1:0]    write_imag_i;
  logic                  result_valid_o;
  logic [FIELD_W-1:0]    read_real_o;
  logic [FIELD_W-1:0]    read_imag_o;
  logic                  status_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_W-1:0]      cfg_data_i;

  gate_sweep_scoreboard sb = new();
  int unsigned          idle_pct;

  controlled_gate_state_sweep_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .control_qubit_i (control_qubit_i),
    .target_qubit_i  (target_qubit_i),
    .amp_address_i   (amp_address_i),
    .write_real_i    (write_real_i),
    .write_imag_i    (write_imag_i),
    .result_valid_o  (result_valid_o),
    .read_real_o     (read_real_o),
    .read_imag_o     (read_imag_o),
    .status_o        (status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      sb.check_result(read_real_o, read_imag_o, status_o);
    end
  end

  function automatic logic [FIELD_W-1:0] pick_part();
    case ($urandom_range(0, 5))
      0: return PART_MIN;
      1: return PART_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input func_e f, input logic [QUBIT_W-1:0] ctl,
                           input logic [QUBIT_W-1:0] tgt,
                           input logic [AMP_ADDR_W-1:0] addr,
                           input logic [FIELD_W-1:0] wr,
                           input logic [FIELD_W-1:0] wi);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start           <= 1'b1;
    func_i          <= f;
    control_qubit_i <= ctl;
    target_qubit_i  <= tgt;
    amp_address_i   <= addr;
    write_real_i    <= wr;
    write_imag_i    <= wi;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_item(f, ctl, tgt, addr, wr, wi);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_results.size() != 0 || busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_qubit_count(input logic [CFG_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.qubit_count = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    func_e                 f;
    logic [QUBIT_W-1:0]    ctl;
    logic [QUBIT_W-1:0]    tgt;
    logic [AMP_ADDR_W-1:0] addr;
    int unsigned           roll;
    int unsigned           n;
    int unsigned           size;
    bit                    found;
    n    = sb.active_qubits();
    size = 1 << n;
    ctl  = QUBIT_W'($urandom);
    tgt  = QUBIT_W'($urandom);
    addr = ($urandom_range(0, 9) == 0) ? AMP_ADDR_W'($urandom)
                                       : AMP_ADDR_W'($urandom_range(0, size - 1));
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      f = FUNC_WRITE;
    end else if (roll < 70) begin
      f = FUNC_READ;
      if (addr < size && !sb.written[addr]) begin
        found = 1'b0;
        for (int k = 0; k < size && !found; k++) begin
          if (sb.written[(addr + k) % size]) begin
            addr  = AMP_ADDR_W'((addr + k) % size);
            found = 1'b1;
          end
        end
        if (!found) begin
          f = FUNC_WRITE;
        end
      end
    end else begin
      f = (roll < 85) ? FUNC_CNOT : FUNC_CZ;
      if ($urandom_range(0, 7) != 0) begin
        ctl = QUBIT_W'($urandom_range(0, n - 1));
        tgt = QUBIT_W'($urandom_range(0, n - 2));
        if (tgt >= ctl) begin
          tgt = tgt + QUBIT_W'(1);
        end
      end
    end
    send_item(f, ctl, tgt, addr, pick_part(), pick_part());
  endtask

  initial begin
    logic [CFG_W-1:0] qcount_plan [PLAN_LEN];
    rst_ni          = 1'b0;
    start           = 1'b0;
    func_i          = '0;
    control_qubit_i = '0;
    target_qubit_i  = '0;
    amp_address_i   = '0;
    write_real_i    = '0;
    write_imag_i    = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    idle_pct        = 25;
    qcount_plan     = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd15, 4'd5, 4'd6, 4'd2, 4'd10,
                        4'd7, 4'd3};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-size state straight out of reset
    send_item(FUNC_WRITE, '0, '0, 10'd1023, PART_MAX, PART_MIN);
    send_item(FUNC_READ, '0, '0, 10'd1023, '0, '0);

    write_qubit_count(4'd3);
    send_item(FUNC_WRITE, '0, '0, 10'd0, PART_MAX, PART_MIN);
    send_item(FUNC_WRITE, '0, '0, 10'd1, PART_MIN, PART_MAX);
    send_item(FUNC_WRITE, '0, '0, 10'd2, '0, '1);
    send_item(FUNC_WRITE, '0, '0, 10'd3, PART_MIN, '0);
    send_item(FUNC_WRITE, '0, '0, 10'd4, '1, 32'h4000_0000);
    send_item(FUNC_WRITE, '0, '0, 10'd5, $urandom, $urandom);
    send_item(FUNC_WRITE, '1, '1, 10'd6, 32'hc000_0000, PART_MIN);
    send_item(FUNC_WRITE, '0, '0, 10'd7, $urandom, $urandom);
    send_item(FUNC_WRITE, '0, '0, 10'd8, '1, '1);
    send_item(FUNC_READ, '0, '0, 10'd1023, '0, '0);
    send_item(FUNC_READ, '0, '0, 10'd0, '0, '0);
    send_item(FUNC_CNOT, 4'd0, 4'd1, '1, '1, '1);
    send_item(FUNC_CZ, 4'd2, 4'd1, '0, '0, '0);
    send_item(FUNC_CZ, 4'd0, 4'd1, '0, '0, '0);
    send_item(FUNC_CNOT, 4'd1, 4'd1, '0, '0, '0);
    send_item(FUNC_CNOT, 4'd3, 4'd0, '0, '0, '0);
    send_item(FUNC_CZ, 4'd0, 4'd15, '0, '0, '0);
    send_item(FUNC_CNOT, 4'd2, 4'd0, '0, '0, '0);
    send_item(FUNC_READ, '0, '0, 10'd1, '0, '0);
    send_item(FUNC_READ, '0, '0, 10'd3, '0, '0);
    send_item(FUNC_READ, '0, '0, 10'd6, '0, '0);
    send_item(FUNC_READ, '0, '0, 10'd7, '0, '0);

    for (int p = 0; p < PLAN_LEN; p++) begin
      write_qubit_count(qcount_plan[p]);
      idle_pct = (p == PLAN_LEN - 1 || p % 3 == 2) ? 0 : 30;
      repeat (ITEMS_PER_PHASE) random_item();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
